@@ rtl/core/lcc_pkg.sv @@
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types, constants and the byte-wise CRC-16 update for the line checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lcc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CrcW    = 16;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned AccW    = 20;

  localparam logic [CrcW-1:0]  CrcInit      = 16'hFFFF;
  localparam logic [CrcW-1:0]  CrcPoly      = 16'h8408;
  localparam logic [CrcW-1:0]  AccMax       = 16'hFFFF;
  localparam logic [ByteW-1:0] LineEndReset = 8'd10;
  localparam logic [ByteW-1:0] SepReset     = 8'd124;
  localparam logic [ByteW-1:0] CharZero     = 8'h30;
  localparam logic [ByteW-1:0] CharNine     = 8'h39;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_END  = 4'd0,
    REG_SEPARATOR = 4'd1
  } cfg_reg_e;

  // reflected crc, one byte, lsb first
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/lcc_if.sv @@
// ----------------------------------------------------------------------------
// lcc_if
// Handshake channels of the line checker: received bytes, results, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lcc_res_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic [15:0] crc_computed;
  logic [15:0] crc_received;
  logic        had_separator;
  logic [15:0] mismatch_count;

  modport source (output valid, output crc_ok, output crc_computed,
                  output crc_received, output had_separator,
                  output mismatch_count, input ready);
  modport sink   (input valid, input crc_ok, input crc_computed,
                  input crc_received, input had_separator,
                  input mismatch_count, output ready);
endinterface

interface lcc_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] reg_idx;
  logic [7:0] wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/core/line_crc16_checker.sv @@
// ----------------------------------------------------------------------------
// line_crc16_checker
// Checks reflected CRC-16 text lines against the decimal checksum after a separator, or for a zero residue without one.
// A line-end beat's result is registered and appears in the output register in the next cycle.
// Takes one byte per cycle unless stalled; the crc and decimal update are combinational.
// Input stalls only while a result waits and the receiver holds it off.
// Reset clears line state, counter and output valid; config to 10 and 124.
// ----------------------------------------------------------------------------
`default_nettype none

module line_crc16_checker
  import lcc_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  lcc_byte_if.sink  rx_i,
  lcc_res_if.source res_o,
  lcc_cfg_if.sink   cfg_i
);

  logic [ByteW-1:0] line_end_q, sep_q;

  logic [CrcW-1:0] crc_run_q, crc_run_d;
  logic [CrcW-1:0] crc_sep_q, crc_sep_d;
  logic [CrcW-1:0] acc_q, acc_d;
  logic            ovf_q, ovf_d;
  logic            ended_q, ended_d;
  logic            seen_q, seen_d;
  logic            nonempty_q, nonempty_d;
  logic [CrcW-1:0] err_q, err_d;

  logic            out_valid_q, out_valid_d;
  logic            ok_q, ok_d;
  logic [CrcW-1:0] comp_q, comp_d;
  logic [CrcW-1:0] recv_q, recv_d;
  logic            had_sep_q, had_sep_d;

  logic            in_acc;
  logic            emit;
  logic [ByteW-1:0] b;
  logic [AccW-1:0] acc_next;
  logic            is_digit;

  // config port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_end_q <= LineEndReset;
      sep_q      <= SepReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_idx)
        REG_LINE_END:  line_end_q <= cfg_i.wdata;
        REG_SEPARATOR: sep_q      <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

  // byte handling
  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign in_acc     = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign is_digit   = (b >= CharZero) && (b <= CharNine);
  assign acc_next   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                    + {{(AccW-ByteW){1'b0}}, b - CharZero};

  always_comb begin
    crc_run_d  = crc_run_q;
    crc_sep_d  = crc_sep_q;
    acc_d      = acc_q;
    ovf_d      = ovf_q;
    ended_d    = ended_q;
    seen_d     = seen_q;
    nonempty_d = nonempty_q;
    err_d      = err_q;
    emit       = 1'b0;
    ok_d       = ok_q;
    comp_d     = comp_q;
    recv_d     = recv_q;
    had_sep_d  = had_sep_q;

    if (in_acc) begin
      if (b == line_end_q) begin
        if (nonempty_q) begin
          emit      = 1'b1;
          had_sep_d = seen_q;
          if (seen_q) begin
            comp_d = crc_sep_q;
            recv_d = acc_q;
            ok_d   = !ovf_q && (acc_q == crc_sep_q);
          end else begin
            comp_d = crc_run_q;
            recv_d = '0;
            ok_d   = (crc_run_q == '0);
          end
          if (!ok_d && (err_q != AccMax)) begin
            err_d = err_q + 1'b1;
          end
        end
        crc_run_d  = CrcInit;
        crc_sep_d  = CrcInit;
        acc_d      = '0;
        ovf_d      = 1'b0;
        ended_d    = 1'b0;
        seen_d     = 1'b0;
        nonempty_d = 1'b0;
      end else begin
        nonempty_d = 1'b1;
        if (b == sep_q) begin
          crc_sep_d = crc_run_q;
          seen_d    = 1'b1;
          acc_d     = '0;
          ovf_d     = 1'b0;
          ended_d   = 1'b0;
        end else if (!ended_q) begin
          if (is_digit) begin
            if (!ovf_q) begin
              if (acc_next > {{(AccW-CrcW){1'b0}}, AccMax}) begin
                ovf_d = 1'b1;
                acc_d = AccMax;
              end else begin
                acc_d = acc_next[CrcW-1:0];
              end
            end
          end else begin
            ended_d = 1'b1;
          end
        end
        crc_run_d = crc_byte(crc_run_q, b);
      end
    end
  end

  assign out_valid_d = (out_valid_q && !res_o.ready) || emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_run_q   <= CrcInit;
      crc_sep_q   <= CrcInit;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      ended_q     <= 1'b0;
      seen_q      <= 1'b0;
      nonempty_q  <= 1'b0;
      err_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      crc_run_q   <= crc_run_d;
      crc_sep_q   <= crc_sep_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      ended_q     <= ended_d;
      seen_q      <= seen_d;
      nonempty_q  <= nonempty_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      ok_q      <= ok_d;
      comp_q    <= comp_d;
      recv_q    <= recv_d;
      had_sep_q <= had_sep_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.crc_ok         = ok_q;
  assign res_o.crc_computed   = comp_q;
  assign res_o.crc_received   = recv_q;
  assign res_o.had_separator  = had_sep_q;
  assign res_o.mismatch_count = err_q;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives received bytes into the line checker and predicts each line verdict
// with a bitwise crc and a decimal parser. Every result beat is compared field
// by field. The run covers several line-end and separator settings, random
// stalls on both sides and a long result hold-off.
// ----------------------------------------------------------------------------

module testbench;
  import lcc_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned LongHold   = 200;

  typedef struct packed {
    logic        ok;
    logic [15:0] computed;
    logic [15:0] received;
    logic        had_sep;
    logic [15:0] count;
  } line_verdict_t;

  class crc_line_scoreboard;
    logic [7:0]    line_end;
    logic [7:0]    separator;
    logic [15:0]   crc_run;
    logic [15:0]   crc_sep;
    logic [15:0]   num;
    logic [15:0]   fails;
    bit            num_ovf;
    bit            num_done;
    bit            sep_seen;
    bit            line_started;
    line_verdict_t verdicts_due[$];
    int unsigned   fail_count;

    function new();
      line_end   = LineEndReset;
      separator  = SepReset;
      fails      = '0;
      fail_count = 0;
      new_line();
    endfunction

    static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      int          i;
      c = crc;
      for (i = 0; i < 8; i++) begin
        if (c[0] ^ b[i]) begin
          c = (c >> 1) ^ 16'h8408;
        end else begin
          c = c >> 1;
        end
      end
      return c;
    endfunction

    function void new_line();
      crc_run      = CrcInit;
      crc_sep      = CrcInit;
      num          = '0;
      num_ovf      = 1'b0;
      num_done     = 1'b0;
      sep_seen     = 1'b0;
      line_started = 1'b0;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] %s", $time, msg);
      fail_count++;
    endtask

    function void write_reg(cfg_reg_e idx, logic [7:0] d);
      case (idx)
        REG_LINE_END: begin
          line_end = d;
        end
        REG_SEPARATOR: begin
          separator = d;
        end
        default: begin
        end
      endcase
    endfunction

    function void accept_byte(logic [7:0] b);
      line_verdict_t v;
      int unsigned   acc;
      if (b == line_end) begin
        if (line_started) begin
          if (sep_seen) begin
            v.computed = crc_sep;
            v.received = num;
            v.ok       = !num_ovf && (num == crc_sep);
          end else begin
            v.computed = crc_run;
            v.received = '0;
            v.ok       = (crc_run == 16'h0000);
          end
          if (!v.ok && fails != 16'hFFFF) begin
            fails = fails + 16'd1;
          end
          v.had_sep = sep_seen;
          v.count   = fails;
          verdicts_due.push_back(v);
        end
        new_line();
      end else begin
        line_started = 1'b1;
        if (b == separator) begin
          crc_sep  = crc_run;
          sep_seen = 1'b1;
          num      = '0;
          num_ovf  = 1'b0;
          num_done = 1'b0;
        end else if (!num_done) begin
          if (b >= CharZero && b <= CharNine) begin
            if (!num_ovf) begin
              acc = num * 10 + (b - CharZero);
              if (acc > 65535) begin
                num_ovf = 1'b1;
                num     = AccMax;
              end else begin
                num = acc[15:0];
              end
            end
          end else begin
            num_done = 1'b1;
          end
        end
        crc_run = crc16_step(crc_run, b);
      end
    endfunction

    task check_verdict(line_verdict_t got);
      line_verdict_t want;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat, count %0d", got.count));
      end else begin
        want = verdicts_due.pop_front();
        if (got.ok !== want.ok)
          report_mismatch($sformatf("crc_ok %b, want %b", got.ok, want.ok));
        if (got.computed !== want.computed)
          report_mismatch($sformatf("crc_computed %h, want %h", got.computed,
                                    want.computed));
        if (got.received !== want.received)
          report_mismatch($sformatf("crc_received %0d, want %0d", got.received,
                                    want.received));
        if (got.had_sep !== want.had_sep)
          report_mismatch($sformatf("had_separator %b, want %b", got.had_sep,
                                    want.had_sep));
        if (got.count !== want.count)
          report_mismatch($sformatf("mismatch_count %0d, want %0d", got.count,
                                    want.count));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  lcc_byte_if rx_if ();
  lcc_res_if  res_if ();
  lcc_cfg_if  cfg_if ();

  line_crc16_checker DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  crc_line_scoreboard sb = new();

  logic [7:0]  line_buf[$];
  logic [7:0]  le_now;
  logic [7:0]  sep_now;
  bit          idle_on;
  bit          hold_request;
  int unsigned bytes_sent;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("line_crc16_checker: mismatch");
      $finish;
    end
  end

  // results first, so a beat never meets an expectation from the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        sb.check_verdict(line_verdict_t'{res_if.crc_ok, res_if.crc_computed,
                                         res_if.crc_received, res_if.had_separator,
                                         res_if.mismatch_count});
      end
      if (rx_if.valid && rx_if.ready) begin
        sb.accept_byte(rx_if.rx_byte);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_reg(cfg_reg_e'(cfg_if.reg_idx), cfg_if.wdata);
      end
    end
  end

  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        res_if.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      res_if.ready <= 1'b1;
    end
  end

  task automatic put_byte(logic [7:0] b);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    bytes_sent++;
  endtask

  task automatic flush_line();
    foreach (line_buf[i]) begin
      put_byte(line_buf[i]);
    end
    line_buf.delete();
  endtask

  task automatic drain();
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_e idx, logic [7:0] d);
    drain();
    @(negedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.reg_idx <= idx;
    cfg_if.wdata   <= d;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == REG_LINE_END) begin
      le_now = d;
    end else begin
      sep_now = d;
    end
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == le_now || b == sep_now) b = b + 8'd1;
    return b;
  endfunction

  function automatic void add_text(int unsigned n);
    repeat (n) line_buf.push_back(text_byte());
  endfunction

  function automatic logic [15:0] buf_crc();
    logic [15:0] c;
    c = CrcInit;
    foreach (line_buf[i]) c = crc_line_scoreboard::crc16_step(c, line_buf[i]);
    return c;
  endfunction

  function automatic void add_decimal(int unsigned v);
    logic [7:0]  digits[$];
    int unsigned r;
    r = v;
    do begin
      digits.push_front(CharZero + 8'(r % 10));
      r = r / 10;
    end while (r != 0);
    foreach (digits[i]) line_buf.push_back(digits[i]);
  endfunction

  function automatic void add_good_line(int unsigned n);
    logic [15:0] crc;
    add_text(n);
    crc = buf_crc();
    line_buf.push_back(sep_now);
    add_decimal(crc);
    line_buf.push_back(le_now);
  endfunction

  task automatic random_line();
    int unsigned kind;
    logic [15:0] crc;
    kind = $urandom_range(0, 19);
    line_buf.delete();
    if (kind <= 11) begin
      add_good_line($urandom_range(0, 10));
    end else if (kind == 17) begin
      repeat ($urandom_range(1, 2)) line_buf.push_back(le_now);
    end else if (kind == 18) begin
      repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      add_text($urandom_range(0, 10));
      crc = buf_crc();
      if (kind == 12) begin
        line_buf.push_back(sep_now);
        add_decimal(crc ^ 16'($urandom_range(1, 65535)));
      end else if (kind == 13) begin
        line_buf.push_back(sep_now);
        add_decimal($urandom_range(65536, 9999999));
      end else if (kind == 14) begin
        line_buf.push_back(sep_now);
        add_decimal(crc);
        line_buf.push_back(text_byte());
        add_decimal($urandom_range(0, 999));
      end else if (kind == 15) begin
        line_buf.push_back(sep_now);
        add_text($urandom_range(0, 3));
        crc = buf_crc();
        line_buf.push_back(sep_now);
        add_decimal(crc);
      end else if (kind == 16) begin
        if ($urandom_range(0, 1) == 1) begin
          line_buf.push_back(crc[7:0]);
          line_buf.push_back(crc[15:8]);
        end
      end else begin
        line_buf.push_back(sep_now);
        repeat ($urandom_range(0, 3)) line_buf.push_back(CharZero);
        if ($urandom_range(0, 1) == 1) begin
          add_decimal(crc);
        end
      end
      line_buf.push_back(le_now);
    end
    flush_line();
  endtask

  task automatic run_random(int unsigned n);
    int unsigned target;
    target = bytes_sent + n;
    while (bytes_sent < target) random_line();
  endtask

  initial begin
    logic [15:0] crc;
    rst_n          = 1'b0;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.reg_idx = REG_LINE_END;
    cfg_if.wdata   = '0;
    le_now         = LineEndReset;
    sep_now        = SepReset;
    idle_on        = 1'b1;
    hold_request   = 1'b0;
    bytes_sent     = 0;
    cycles         = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty line, then extreme byte values with no separator
    line_buf = '{le_now, 8'h00, 8'hFF, le_now};
    flush_line();
    // crc appended low byte first leaves a zero residue
    line_buf.push_back("x");
    crc = buf_crc();
    line_buf.push_back(crc[7:0]);
    line_buf.push_back(crc[15:8]);
    line_buf.push_back(le_now);
    flush_line();
    // empty text against the largest value
    line_buf.push_back(sep_now);
    add_decimal(65535);
    line_buf.push_back(le_now);
    // two separators and an overflowing value
    line_buf.push_back("a");
    line_buf.push_back(sep_now);
    line_buf.push_back("b");
    line_buf.push_back(sep_now);
    add_decimal(70000);
    line_buf.push_back(le_now);
    // parse stops at the first non-digit
    line_buf.push_back(sep_now);
    line_buf.push_back("1");
    line_buf.push_back("x");
    line_buf.push_back("2");
    line_buf.push_back(le_now);
    flush_line();

    run_random(50);
    hold_request = 1'b1;
    repeat (20) begin
      add_good_line($urandom_range(0, 2));
      flush_line();
    end
    run_random(50);

    set_reg(REG_LINE_END, 8'h00);
    set_reg(REG_SEPARATOR, 8'hFF);
    run_random(60);
    drain();
    run_random(40);

    set_reg(REG_LINE_END, 8'hFF);
    set_reg(REG_SEPARATOR, 8'h00);
    run_random(60);

    set_reg(REG_LINE_END, 8'd13);
    set_reg(REG_SEPARATOR, 8'd13);
    run_random(60);

    repeat (2) begin
      set_reg(REG_LINE_END, 8'($urandom_range(0, 255)));
      set_reg(REG_SEPARATOR, 8'($urandom_range(0, 255)));
      run_random(60);
    end

    // last part runs without idling on either side
    set_reg(REG_LINE_END, LineEndReset);
    set_reg(REG_SEPARATOR, SepReset);
    idle_on = 1'b0;
    drain();
    run_random(60);

    drain();
    repeat (5) @(posedge clk);
    if (sb.verdicts_due.size() != 0) begin
      sb.report_mismatch("results missing at end of run");
    end
    if (sb.fail_count == 0) begin
      $display("line_crc16_checker: match");
    end else begin
      $display("line_crc16_checker: mismatch");
    end
    $finish;
  end

endmodule
